@@ rtl/core/bdpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
   localparam logic [CNT_W-1:0] LONG_RST     = 16'd3000;

   // register index within the CSR map
   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_LONG     = 1'b1;

   // event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   localparam logic LVL_PRESSED  = 1'b0;
   localparam logic LVL_RELEASED = 1'b1;

   typedef struct packed {
      logic raw_level;
      logic take_event;
   } req_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic       stable_level;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] long_press_ticks;
   } cfg_type;

endpackage

@@ rtl/core/bdpc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_core
// Per-tick debounce and press timing state; updates on each accepted word.
// ----------------------------------------------------------------------------
module bdpc_core
   import bdpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tick,
   input  req_type req_data,
   input  cfg_type cfg,
   output rsp_type result
);

   logic             last_raw_ff, last_raw_in;
   logic             stable_ff, stable_in;
   logic [CNT_W-1:0] settle_ff, settle_in;
   logic [CNT_W-1:0] hold_ff, hold_in;
   logic             long_rep_ff, long_rep_in;
   logic [1:0]       pend_ff, pend_in;

   logic             accepted;
   logic             press_edge;
   logic             release_edge;
   logic             long_hit;
   logic [CNT_W-1:0] hold_inc;
   logic             long_rep_mid;
   logic [1:0]       report;

   always_comb begin
      last_raw_in = req_data.raw_level;
      if (req_data.raw_level != last_raw_ff) begin
         settle_in = '0;
      end else if (settle_ff == CNT_MAX) begin
         settle_in = CNT_MAX;
      end else begin
         settle_in = settle_ff + 1'b1;
      end
      hold_inc = (hold_ff == CNT_MAX) ? CNT_MAX : hold_ff + 1'b1;

      accepted     = settle_in >= cfg.debounce_ticks;
      press_edge   = accepted && (req_data.raw_level == LVL_PRESSED)
                     && (stable_ff == LVL_RELEASED);
      release_edge = accepted && (req_data.raw_level == LVL_RELEASED)
                     && (stable_ff == LVL_PRESSED);

      stable_in    = accepted ? req_data.raw_level : stable_ff;
      hold_in      = press_edge ? '0 : hold_inc;
      long_rep_mid = press_edge ? 1'b0 : long_rep_ff;
      long_hit     = accepted && (req_data.raw_level == LVL_PRESSED) && !long_rep_mid
                     && (hold_in >= cfg.long_press_ticks);

      report      = pend_ff;
      long_rep_in = long_rep_mid;
      if (long_hit) begin
         report      = EV_LONG;
         long_rep_in = 1'b1;
      end else if (release_edge) begin
         if (!long_rep_mid) begin
            report = EV_SHORT;
         end
         long_rep_in = 1'b0;
      end
      pend_in = req_data.take_event ? EV_NONE : report;

      result.event_code   = report;
      result.stable_level = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= LVL_RELEASED;
         stable_ff   <= LVL_RELEASED;
         settle_ff   <= '0;
         hold_ff     <= '0;
         long_rep_ff <= 1'b0;
         pend_ff     <= EV_NONE;
      end else if (tick) begin
         last_raw_ff <= last_raw_in;
         stable_ff   <= stable_in;
         settle_ff   <= settle_in;
         hold_ff     <= hold_in;
         long_rep_ff <= long_rep_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

@@ rtl/core/button_debounce_press_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces an active-low button sampled once per word and classifies
// short and long presses, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each request word is one time tick. The tick updates the debounce and hold
// state in the cycle it is accepted and its response word is registered in the
// output register, or in the skid while that register waits. One word is taken
// every cycle while the skid is empty. A two-entry output stage (output register
// plus skid) lets the block keep taking words while one response waits.
// Registers: 0x0 debounce_ticks, 0x4 long_press_ticks (16 bit, zero-extended
// on read); write them only while the block is idle.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit
   import bdpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type cfg_ff;
   rsp_type result;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    accept;
   logic    taken;
   logic    csr_wr;
   logic    reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RST;
         cfg_ff.long_press_ticks <= LONG_RST;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_DEBOUNCE: cfg_ff.debounce_ticks   <= pwdata[CNT_W-1:0];
            REG_LONG:     cfg_ff.long_press_ticks <= pwdata[CNT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DEBOUNCE: prdata = {{(CSR_DW-CNT_W){1'b0}}, cfg_ff.debounce_ticks};
         REG_LONG:     prdata = {{(CSR_DW-CNT_W){1'b0}}, cfg_ff.long_press_ticks};
         default:      prdata = '0;
      endcase
   end

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign taken     = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   bdpc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .tick     (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (taken) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else if (accept) begin
               out_ff <= result;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff) begin
               out_ff       <= result;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

   // skid only ever holds a word behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // a word taken while the output is stalled must land in the skid
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("stalled word lost");

   // no reserved event code reaches the output
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.event_code == EV_NONE || out_ff.event_code == EV_SHORT
                        || out_ff.event_code == EV_LONG))
      else $error("reserved event code");

endmodule
